// ===== rtl/core/servo_write_packet_framer_unit_defines.svh =====
// Assertion macros used by the framer datapath.
`ifndef SERVO_WRITE_PACKET_FRAMER_UNIT_DEFINES_SVH
`define SERVO_WRITE_PACKET_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SWPF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SWPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/swpf_pkg.sv =====
package swpf_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'hFF;
	localparam logic [3:0] LEN_OFFSET  = 4'd3;
	localparam logic [3:0] DATA_START  = 4'd6;
	localparam logic [3:0] ID_POS      = 4'd2;
	localparam logic [3:0] LEN_POS     = 4'd3;
	localparam logic [3:0] OPCODE_POS  = 4'd4;
	localparam logic [3:0] ADDR_POS    = 4'd5;

	localparam logic [7:0] OPCODE_RESET = 8'd3;

	localparam logic [1:0] CFG_WRITE_OPCODE  = 2'd0;
	localparam logic [1:0] CFG_DIR_PRESENT   = 2'd1;
	localparam logic [1:0] CFG_INVERT_DIR    = 2'd2;

	localparam logic [1:0] DRIVE_NONE = 2'd0;
	localparam logic [1:0] DRIVE_LOW  = 2'd1;
	localparam logic [1:0] DRIVE_HIGH = 2'd2;

	localparam logic [1:0] KIND_ONE_BYTE = 2'd0;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  servo_id;
		logic [7:0]  reg_addr;
		logic [15:0] value_first;
		logic [15:0] value_second;
		logic [15:0] value_third;
	} req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last_byte;
		logic [1:0] direction_drive;
	} rsp_t;

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} state_t;

	typedef struct packed {
		logic load;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic is_last;
	} status_t;

endpackage

// ===== rtl/core/swpf_ctrl.sv =====
module swpf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  swpf_pkg::status_t status,
	output swpf_pkg::cmd_t    cmd
);

	swpf_pkg::state_t state_q;
	swpf_pkg::state_t state_d;
	logic             emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			swpf_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = swpf_pkg::ST_SEND;
				end
			end
			swpf_pkg::ST_SEND: begin
				if (status.out_free && status.is_last && !req_valid) begin
					state_d = swpf_pkg::ST_IDLE;
				end
			end
			default: state_d = swpf_pkg::ST_IDLE;
		endcase
	end

	// A new request is taken when idle, or in the cycle the checksum word is loaded.
	always_comb begin
		emit      = (state_q == swpf_pkg::ST_SEND) && status.out_free;
		req_ready = (state_q == swpf_pkg::ST_IDLE) || (emit && status.is_last);
		cmd.emit  = emit;
		cmd.load  = req_valid && req_ready;
	end

endmodule

// ===== rtl/core/swpf_dp.sv =====
`include "servo_write_packet_framer_unit_defines.svh"

module swpf_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  swpf_pkg::cmd_t    cmd,
	input  swpf_pkg::req_t    req,
	input  logic [7:0]        write_opcode,
	input  logic              direction_pin_present,
	input  logic              invert_direction,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output swpf_pkg::rsp_t    rsp,
	output swpf_pkg::status_t status
);

	logic [7:0]  id_q;
	logic [7:0]  addr_q;
	logic [7:0]  opcode_q;
	logic [3:0]  len_q;
	logic [47:0] data_q;
	logic [1:0]  drive_q;
	logic [3:0]  idx_q;
	logic [3:0]  last_idx_q;
	logic [7:0]  sum_q;
	logic        out_valid_q;
	swpf_pkg::rsp_t out_q;

	logic [3:0]  ndata;
	logic [1:0]  drive_d;
	logic [3:0]  data_pos;
	logic [7:0]  data_byte;
	logic [7:0]  cur_byte;
	logic        is_last;

	always_comb begin
		if (req.req_type == swpf_pkg::KIND_ONE_BYTE) begin
			ndata = 4'd1;
		end else begin
			ndata = {1'b0, req.req_type, 1'b0};
		end
		if (!direction_pin_present) begin
			drive_d = swpf_pkg::DRIVE_NONE;
		end else if (invert_direction) begin
			drive_d = swpf_pkg::DRIVE_LOW;
		end else begin
			drive_d = swpf_pkg::DRIVE_HIGH;
		end
	end

	always_comb begin
		is_last  = (idx_q == last_idx_q);
		data_pos = idx_q - swpf_pkg::DATA_START;
		unique case (data_pos[2:0])
			3'd0:    data_byte = data_q[7:0];
			3'd1:    data_byte = data_q[15:8];
			3'd2:    data_byte = data_q[23:16];
			3'd3:    data_byte = data_q[31:24];
			3'd4:    data_byte = data_q[39:32];
			3'd5:    data_byte = data_q[47:40];
			default: data_byte = data_q[7:0];
		endcase
		priority if (is_last) begin
			cur_byte = ~sum_q;
		end else if (idx_q < swpf_pkg::ID_POS) begin
			cur_byte = swpf_pkg::HEADER_BYTE;
		end else if (idx_q == swpf_pkg::ID_POS) begin
			cur_byte = id_q;
		end else if (idx_q == swpf_pkg::LEN_POS) begin
			cur_byte = {4'd0, len_q};
		end else if (idx_q == swpf_pkg::OPCODE_POS) begin
			cur_byte = opcode_q;
		end else if (idx_q == swpf_pkg::ADDR_POS) begin
			cur_byte = addr_q;
		end else begin
			cur_byte = data_byte;
		end
	end

	// Request capture; one-byte requests carry only the low byte of the first value.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q       <= req.servo_id;
			addr_q     <= req.reg_addr;
			opcode_q   <= write_opcode;
			len_q      <= ndata + swpf_pkg::LEN_OFFSET;
			data_q     <= {req.value_third, req.value_second, req.value_first};
			drive_q    <= drive_d;
		end
	end

	// The byte counter stops on the checksum byte until the next request is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			last_idx_q <= swpf_pkg::DATA_START;
			sum_q      <= '0;
		end else if (cmd.load) begin
			idx_q      <= '0;
			last_idx_q <= ndata + swpf_pkg::DATA_START;
			sum_q      <= '0;
		end else if (cmd.emit) begin
			if (!is_last) begin
				idx_q <= idx_q + 4'd1;
			end
			if (idx_q >= swpf_pkg::ID_POS && !is_last) begin
				sum_q <= sum_q + cur_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.tx_byte         <= cur_byte;
			out_q.last_byte       <= is_last;
			out_q.direction_drive <= drive_q;
		end
	end

	assign rsp_valid       = out_valid_q;
	assign rsp             = out_q;
	assign status.out_free = !out_valid_q || rsp_ready;
	assign status.is_last  = is_last;

	`SWPF_ASSERT_NOW(a_idx_bounded, 1'b1, idx_q <= last_idx_q, "byte index ran past checksum")
	`SWPF_ASSERT_NEXT(a_last_flag, cmd.emit && is_last, rsp_valid && rsp.last_byte,
		"checksum word not flagged last")
	`SWPF_ASSERT_NEXT(a_header, cmd.emit && (idx_q < swpf_pkg::ID_POS),
		rsp.tx_byte == swpf_pkg::HEADER_BYTE && !rsp.last_byte, "bad header word")
	`SWPF_ASSERT_NOW(a_drive_code, rsp_valid, rsp.direction_drive != 2'd3,
		"invalid direction drive code")

endmodule

// ===== rtl/core/servo_write_packet_framer_unit.sv =====
// Servo bus write packet framer. Each request word on the req channel becomes one
// protocol write packet, sent as one byte per word on the rsp channel: two 0xFF
// header bytes, the servo id, the length (data bytes plus 3), the write opcode,
// the register address, the data bytes (one byte, or one to three 16-bit values
// low byte first) and an inverted 8-bit checksum over id through data, which is
// flagged with last_byte. Every word also carries the action for the transmit
// enable pin. A packet is 8, 9, 11 or 13 words long and leaves at one word per
// cycle while rsp_ready stays high; the rate is set by the single byte-wide output
// register, and the next request is taken in the cycle that the checksum word is
// loaded. Configuration (opcode, pin presence, pin polarity) is written through
// cfg_we, cfg_index and cfg_data; the user must write it only while the block
// is idle (not enforced); it is sampled when a request is accepted.
module servo_write_packet_framer_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  swpf_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output swpf_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_index,
	input  logic [7:0]     cfg_data
);

	// Configuration registers. An index beyond the last register is ignored.
	logic [7:0] write_opcode_q;
	logic       dir_present_q;
	logic       invert_dir_q;

	swpf_pkg::cmd_t    cmd;
	swpf_pkg::status_t status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_opcode_q <= swpf_pkg::OPCODE_RESET;
			dir_present_q  <= 1'b1;
			invert_dir_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				swpf_pkg::CFG_WRITE_OPCODE: write_opcode_q <= cfg_data;
				swpf_pkg::CFG_DIR_PRESENT:  dir_present_q  <= cfg_data[0];
				swpf_pkg::CFG_INVERT_DIR:   invert_dir_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The controller sequences a packet: it takes a request, then steps the
	// datapath one byte each cycle that the output register can accept a word.
	swpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the request, the byte counter, the running checksum
	// and the output register that separates the two channels.
	swpf_dp u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.req                   (req),
		.write_opcode          (write_opcode_q),
		.direction_pin_present (dir_present_q),
		.invert_direction      (invert_dir_q),
		.rsp_ready             (rsp_ready),
		.rsp_valid             (rsp_valid),
		.rsp                   (rsp),
		.status                (status)
	);

endmodule

// ===== bench/servo_write_packet_framer_unit_test.sv =====
// Self-checking bench for the servo bus write packet framer.
module servo_write_packet_framer_unit_test;

	// Kinds of request payload beyond the one-byte kind that the package names.
	localparam logic [1:0] KIND_ONE_SHORT    = 2'd1;
	localparam logic [1:0] KIND_TWO_SHORTS   = 2'd2;
	localparam logic [1:0] KIND_THREE_SHORTS = 2'd3;

	// The fourth register index has no register behind it.
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	// The receiver holds off once, after this many bytes have been checked.
	localparam int HOLD_AT_BYTE = 400;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_PHASE_ITEMS = 50;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_ready;
	swpf_pkg::req_t req = '0;
	logic           rsp_valid;
	logic           rsp_ready = 1'b0;
	swpf_pkg::rsp_t rsp;
	logic           cfg_we = 1'b0;
	logic [1:0]     cfg_index = swpf_pkg::CFG_WRITE_OPCODE;
	logic [7:0]     cfg_data = '0;

	servo_write_packet_framer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Our own copy of the three configuration registers, at their reset values.
	logic [7:0] opcode_shadow = swpf_pkg::OPCODE_RESET;
	logic       pin_present_shadow = 1'b1;
	logic       pin_invert_shadow = 1'b0;

	// Requests waiting to be offered, and packet bytes waiting to come out.
	swpf_pkg::req_t pending_reqs[$];
	swpf_pkg::rsp_t packet_bytes_due[$];

	// When calm is set, neither side idles; it is changed only between phases.
	logic calm = 1'b0;

	int error_count = 0;
	int reqs_accepted = 0;
	int bytes_checked = 0;
	int packets_seen = 0;
	int settings_used = 1;
	int hold_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Build the packet that one request should produce, using the register
	// copies as they stand when the request word is accepted. Data bytes go
	// low byte first; the checksum inverts the 8-bit sum of id through data.
	function automatic void frame_packet(input swpf_pkg::req_t r);
		logic [7:0]     pkt[13];
		logic [7:0]     sum;
		logic [1:0]     drive;
		int             ndata;
		int             len;
		swpf_pkg::rsp_t b;
		pkt[0] = swpf_pkg::HEADER_BYTE;
		pkt[1] = swpf_pkg::HEADER_BYTE;
		pkt[swpf_pkg::ID_POS] = r.servo_id;
		pkt[swpf_pkg::OPCODE_POS] = opcode_shadow;
		pkt[swpf_pkg::ADDR_POS] = r.reg_addr;
		case (r.req_type)
			swpf_pkg::KIND_ONE_BYTE: begin
				ndata = 1;
				pkt[6] = r.value_first[7:0];
			end
			KIND_ONE_SHORT: begin
				ndata = 2;
				pkt[6] = r.value_first[7:0];
				pkt[7] = r.value_first[15:8];
			end
			KIND_TWO_SHORTS: begin
				ndata = 4;
				pkt[6] = r.value_first[7:0];
				pkt[7] = r.value_first[15:8];
				pkt[8] = r.value_second[7:0];
				pkt[9] = r.value_second[15:8];
			end
			default: begin
				ndata = 6;
				pkt[6] = r.value_first[7:0];
				pkt[7] = r.value_first[15:8];
				pkt[8] = r.value_second[7:0];
				pkt[9] = r.value_second[15:8];
				pkt[10] = r.value_third[7:0];
				pkt[11] = r.value_third[15:8];
			end
		endcase
		pkt[swpf_pkg::LEN_POS] = 8'(ndata) + 8'(swpf_pkg::LEN_OFFSET);
		sum = '0;
		for (int i = swpf_pkg::ID_POS; i < swpf_pkg::DATA_START + ndata; i++)
			sum = sum + pkt[i];
		pkt[swpf_pkg::DATA_START + ndata] = ~sum;
		len = swpf_pkg::DATA_START + ndata + 1;
		// An absent pin is never driven, whatever the polarity says.
		if (!pin_present_shadow)
			drive = swpf_pkg::DRIVE_NONE;
		else
			drive = pin_invert_shadow ? swpf_pkg::DRIVE_LOW : swpf_pkg::DRIVE_HIGH;
		for (int i = 0; i < len; i++) begin
			b.tx_byte = pkt[i];
			b.last_byte = (i == len - 1);
			b.direction_drive = drive;
			packet_bytes_due.push_back(b);
		end
	endfunction

	function automatic swpf_pkg::req_t make_req(input logic [1:0] kind,
			input logic [7:0] id, input logic [7:0] addr, input logic [15:0] v1,
			input logic [15:0] v2, input logic [15:0] v3);
		swpf_pkg::req_t r;
		r.req_type = kind;
		r.servo_id = id;
		r.reg_addr = addr;
		r.value_first = v1;
		r.value_second = v2;
		r.value_third = v3;
		return r;
	endfunction

	// Random request with random content; now and then a field is pinned to
	// one of its extremes so that those keep turning up in the random part.
	function automatic swpf_pkg::req_t random_req();
		swpf_pkg::req_t r;
		r.req_type = 2'($urandom_range(3));
		r.servo_id = 8'($urandom);
		r.reg_addr = 8'($urandom);
		r.value_first = 16'($urandom);
		r.value_second = 16'($urandom);
		r.value_third = 16'($urandom);
		if ($urandom_range(7) == 0)
			r.servo_id = $urandom_range(1) ? 8'hFF : 8'h00;
		if ($urandom_range(7) == 0)
			r.value_first = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		return r;
	endfunction

	// Request driver. A word is accepted at an edge where valid and ready are
	// both high; the expected packet is predicted right there. Valid is then
	// either raised again with the next pending word or dropped, decided once
	// per edge so the outputs get a single assignment each.
	always @(posedge clk) begin : req_driver
		logic           next_valid;
		swpf_pkg::req_t next_word;
		next_valid = req_valid;
		next_word = req;
		if (arst_n) begin
			if (req_valid && req_ready) begin
				frame_packet(req);
				reqs_accepted++;
				next_valid = 1'b0;
			end
			if (!next_valid && pending_reqs.size() != 0) begin
				if (calm || $urandom_range(99) >= 22) begin
					next_word = pending_reqs.pop_front();
					next_valid = 1'b1;
				end
			end
		end
		req_valid <= next_valid;
		req <= next_word;
	end

	// Byte monitor and receiver. Each accepted output word is checked field by
	// field against the oldest byte due. Once in the run the receiver stops for
	// a long stretch while the driver keeps offering, so the framer backs up
	// and has to stall its request channel.
	always @(posedge clk) begin : rsp_monitor
		swpf_pkg::rsp_t want;
		logic           next_ready;
		next_ready = 1'b0;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (packet_bytes_due.size() == 0) begin
					$display("%0t: unexpected byte %h last %b drive %0d", $time,
						rsp.tx_byte, rsp.last_byte, rsp.direction_drive);
					error_count++;
				end else begin
					want = packet_bytes_due.pop_front();
					if (rsp.tx_byte !== want.tx_byte
							|| rsp.last_byte !== want.last_byte
							|| rsp.direction_drive !== want.direction_drive) begin
						$display({"%0t: mismatch expected byte %h last %b drive %0d,",
							" got byte %h last %b drive %0d"},
							$time, want.tx_byte, want.last_byte, want.direction_drive,
							rsp.tx_byte, rsp.last_byte, rsp.direction_drive);
						error_count++;
					end
				end
				if (rsp.last_byte === 1'b1)
					packets_seen++;
				bytes_checked++;
				if (bytes_checked == HOLD_AT_BYTE)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else begin
				next_ready = calm || ($urandom_range(99) >= 22);
			end
		end
		rsp_ready <= next_ready;
	end

	// One register write, held for a single edge. The shadow copy keeps only
	// the register's own low bits and ignores an index with no register.
	task automatic write_cfg(input logic [1:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			swpf_pkg::CFG_WRITE_OPCODE: opcode_shadow = data;
			swpf_pkg::CFG_DIR_PRESENT:  pin_present_shadow = data[0];
			swpf_pkg::CFG_INVERT_DIR:   pin_invert_shadow = data[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every request has gone in and every byte has come out, then let
	// the output register settle.
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || packet_bytes_due.size() != 0 || req_valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : sequencer
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part under reset settings: all-ones fields for every kind, all-zero
		// fields for every kind but one short, some with unused value fields set to junk.
		pending_reqs.push_back(make_req(swpf_pkg::KIND_ONE_BYTE, 8'h00, 8'h00, 16'h0000,
			16'h0000, 16'h0000));
		pending_reqs.push_back(make_req(swpf_pkg::KIND_ONE_BYTE, 8'hFF, 8'hFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF));
		pending_reqs.push_back(make_req(KIND_ONE_SHORT, 8'h01, 8'h1E, 16'h0200, 16'hDEAD,
			16'hBEEF));
		pending_reqs.push_back(make_req(KIND_ONE_SHORT, 8'hFF, 8'hFF, 16'hFFFF, 16'h0000,
			16'h0000));
		pending_reqs.push_back(make_req(KIND_TWO_SHORTS, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'hFFFF));
		pending_reqs.push_back(make_req(KIND_TWO_SHORTS, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
			16'h5A5A));
		pending_reqs.push_back(make_req(KIND_THREE_SHORTS, 8'h00, 8'h00, 16'h0000, 16'h0000,
			16'h0000));
		pending_reqs.push_back(make_req(KIND_THREE_SHORTS, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF));
		pending_reqs.push_back(make_req(KIND_THREE_SHORTS, 8'hFE, 8'h20, 16'h1234, 16'h5678,
			16'h9ABC));
		pending_reqs.push_back(make_req(swpf_pkg::KIND_ONE_BYTE, 8'h7F, 8'h80, 16'hAA55,
			16'hFFFF, 16'hFFFF));
		wait_idle();

		// A write to the index with no register must change nothing.
		write_cfg(CFG_UNUSED, 8'hFF);
		pending_reqs.push_back(random_req());
		wait_idle();

		// Pin absent: the wide value keeps only bit 0, which is zero here, and
		// the inverted polarity must not show through.
		write_cfg(swpf_pkg::CFG_WRITE_OPCODE, 8'hFF);
		write_cfg(swpf_pkg::CFG_DIR_PRESENT, 8'hFE);
		write_cfg(swpf_pkg::CFG_INVERT_DIR, 8'h01);
		settings_used++;
		pending_reqs.push_back(make_req(swpf_pkg::KIND_ONE_BYTE, 8'h10, 8'h18, 16'h00C3,
			16'h0000, 16'h0000));
		pending_reqs.push_back(make_req(KIND_ONE_SHORT, 8'h11, 8'h1E, 16'h03FF, 16'h0000,
			16'h0000));
		pending_reqs.push_back(make_req(KIND_TWO_SHORTS, 8'h12, 8'h20, 16'h0155, 16'h02AA,
			16'h0000));
		wait_idle();

		// Pin present and inverted, smallest opcode: the pin is driven low.
		write_cfg(swpf_pkg::CFG_DIR_PRESENT, 8'h01);
		write_cfg(swpf_pkg::CFG_WRITE_OPCODE, 8'h00);
		settings_used++;
		pending_reqs.push_back(make_req(KIND_THREE_SHORTS, 8'hFD, 8'h1E, 16'h8001, 16'h7FFE,
			16'hC003));
		pending_reqs.push_back(make_req(swpf_pkg::KIND_ONE_BYTE, 8'h01, 8'h19, 16'h0001,
			16'h0000, 16'h0000));
		pending_reqs.push_back(make_req(KIND_ONE_SHORT, 8'hFE, 8'h22, 16'hFF00, 16'h0000,
			16'h0000));
		wait_idle();

		// Polarity back to normal through a wide value whose bit 0 is clear.
		write_cfg(swpf_pkg::CFG_INVERT_DIR, 8'h02);
		write_cfg(swpf_pkg::CFG_WRITE_OPCODE, 8'h83);
		settings_used++;
		pending_reqs.push_back(make_req(KIND_TWO_SHORTS, 8'h05, 8'hFF, 16'h00FF, 16'hFF00,
			16'h1111));
		pending_reqs.push_back(make_req(KIND_THREE_SHORTS, 8'h06, 8'h00, 16'hFFFF, 16'h0000,
			16'hFFFF));
		wait_idle();

		// Random part, four phases with different settings. The receiver's long
		// hold-off falls in the first; the second runs with no idling at all.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_cfg(swpf_pkg::CFG_WRITE_OPCODE, 8'($urandom));
					write_cfg(swpf_pkg::CFG_DIR_PRESENT, 8'h01);
					write_cfg(swpf_pkg::CFG_INVERT_DIR, 8'h00);
				end
				1: begin
					write_cfg(swpf_pkg::CFG_WRITE_OPCODE, 8'hFF);
					write_cfg(swpf_pkg::CFG_INVERT_DIR, 8'h01);
					calm <= 1'b1;
				end
				2: begin
					write_cfg(swpf_pkg::CFG_WRITE_OPCODE, 8'h00);
					write_cfg(swpf_pkg::CFG_DIR_PRESENT, 8'h00);
					calm <= 1'b0;
				end
				default: begin
					write_cfg(swpf_pkg::CFG_WRITE_OPCODE, 8'($urandom));
					write_cfg(swpf_pkg::CFG_DIR_PRESENT, 8'($urandom));
					write_cfg(swpf_pkg::CFG_INVERT_DIR, 8'($urandom));
				end
			endcase
			settings_used++;
			for (int n = 0; n < RANDOM_PHASE_ITEMS; n++)
				pending_reqs.push_back(random_req());
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (packet_bytes_due.size() != 0) begin
			$display("%0t: %0d bytes still due at the end", $time, packet_bytes_due.size());
			error_count++;
		end
		$display("Framed %0d requests into %0d packets, %0d bytes checked.",
			reqs_accepted, packets_seen, bytes_checked);
		$display("Used %0d register settings, with one long receiver stall.",
			settings_used);
		if (error_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Safety net: far beyond the slowest correct run.
	initial begin : watchdog
		#2000000;
		$display("%0t: run did not finish in time", $time);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
